// ===== rtl/core/ohlc_pkg.sv =====
// shared types, constants and codes for the ohlc bar aggregator
`timescale 1ns / 1ps

package ohlc_pkg;

	localparam int NUM_SYMBOLS_DEF = 64;
	localparam int PRICE_BITS_DEF  = 32;

	localparam int SYM_W     = 8;
	localparam int TS_W      = 63;
	localparam int PX_W      = 32;
	localparam int OUT_SYM_W = 7;
	localparam int LEN_W     = 47;
	localparam int ACT_W     = 7;
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 4;

	localparam logic [LEN_W-1:0] BAR_LEN_RESET = 47'd60000000000;
	localparam logic [ACT_W-1:0] ACTIVE_RESET  = 7'd64;

	localparam logic [APB_AW-1:0] ADDR_BAR_LEN = 4'h0;
	localparam logic [APB_AW-1:0] ADDR_ACTIVE  = 4'h8;

	typedef struct packed {
		logic [SYM_W-1:0] sym_code;
		logic [TS_W-1:0]  timestamp_ns;
		logic [PX_W-1:0]  price;
	} tick_t;

	typedef struct packed {
		logic [OUT_SYM_W-1:0] bar_symbol;
		logic [TS_W-1:0]      bar_start_ns;
		logic [PX_W-1:0]      bar_open;
		logic [PX_W-1:0]      bar_high;
		logic [PX_W-1:0]      bar_low;
		logic [PX_W-1:0]      bar_close;
	} bar_t;

	typedef struct packed {
		logic [LEN_W-1:0] bar_length_ns;
		logic [ACT_W-1:0] active_symbols;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REM
	} ohlc_state_t;

endpackage

// ===== rtl/core/ohlc_cfg.sv =====
// apb register block for bar length and active symbol count
`timescale 1ns / 1ps

module ohlc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ohlc_pkg::APB_AW-1:0]  paddr,
	input  logic [ohlc_pkg::APB_DW-1:0]  pwdata,
	output logic [ohlc_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output ohlc_pkg::cfg_t               cfg
);
	import ohlc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bar_length_ns  <= BAR_LEN_RESET;
			cfg_q.active_symbols <= ACTIVE_RESET;
		end else if (wr_en) begin
			if (paddr == ADDR_BAR_LEN) begin
				cfg_q.bar_length_ns <= pwdata[LEN_W-1:0];
			end
			if (paddr == ADDR_ACTIVE) begin
				cfg_q.active_symbols <= pwdata[ACT_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_BAR_LEN) begin
			prdata = {{(APB_DW-LEN_W){1'b0}}, cfg_q.bar_length_ns};
		end else if (paddr == ADDR_ACTIVE) begin
			prdata = {{(APB_DW-ACT_W){1'b0}}, cfg_q.active_symbols};
		end
	end

endmodule

// ===== rtl/core/ohlc_table.sv =====
// per-symbol bar table: synchronous memory plus open flags
`timescale 1ns / 1ps

module ohlc_table #(
	parameter int NUM_SYMBOLS = ohlc_pkg::NUM_SYMBOLS_DEF,
	parameter int ENTRY_W     = ohlc_pkg::TS_W + 4 * ohlc_pkg::PRICE_BITS_DEF,
	localparam int IDX_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic               rd_open,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENTRY_W-1:0] wr_data
);
	import ohlc_pkg::*;

	logic [ENTRY_W-1:0]     mem [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] open_q;
	logic                   rd_open_q;
	logic [ENTRY_W-1:0]     rd_data_q;

	// a bar is reopened in the same write that closes it, so flags only set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= '0;
			rd_open_q <= 1'b0;
		end else begin
			if (wr_en) begin
				open_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_open_q <= open_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_open = rd_open_q;
	assign rd_data = rd_data_q;

	// reads and writes are never issued together by the sequencer
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("table read and write in the same cycle");

	a_open_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> open_q[$past(wr_addr)])
		else $error("written entry not marked open");

	a_open_never_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(open_q) >= $countones($past(open_q)))
		else $error("open flag cleared outside reset");

endmodule

// ===== rtl/core/ohlc_rem.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module ohlc_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ohlc_pkg::TS_W-1:0]   dividend,
	input  logic [ohlc_pkg::LEN_W-1:0]  divisor,
	output logic                        done,
	output logic [ohlc_pkg::LEN_W-1:0]  remainder
);
	import ohlc_pkg::*;

	localparam int CNT_W = $clog2(TS_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]  dvd_q;
	logic [LEN_W-1:0] dvs_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   diff;
	logic [LEN_W-1:0] rem_next;

	// partial remainder stays below the divisor, so it fits in LEN_W bits
	assign trial    = {rem_q, dvd_q[TS_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign rem_next = diff[LEN_W] ? trial[LEN_W-1:0] : diff[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TS_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TS_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("remainder done without a run");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvs_q)
		else $error("remainder not below divisor");

endmodule

// ===== rtl/core/tick_to_ohlc_bar_aggregator_unit.sv =====
// top level: tick intake, bar table sequencer, bar output register
`timescale 1ns / 1ps
// an update to an open bar is written in the cycle after its transfer; a tick that
// starts a bar (first tick or rollover) is written once the 63-step remainder unit
// has floored the tick time to the bar length; no new tick is taken until the last
// is written, nor while a completed bar waits on a stalled output; bar_valid is
// registered, set from the eval state once the output slot is free
// reset clears the open flags, the output valid and the registers to defaults

module tick_to_ohlc_bar_aggregator_unit #(
	parameter int NUM_SYMBOLS = ohlc_pkg::NUM_SYMBOLS_DEF,
	parameter int PRICE_BITS  = ohlc_pkg::PRICE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// tick channel
	input  logic                        tick_valid,
	output logic                        tick_stall,
	input  ohlc_pkg::tick_t             tick,
	// completed bar channel
	output logic                        bar_valid,
	input  logic                        bar_stall,
	output ohlc_pkg::bar_t              bar,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ohlc_pkg::APB_AW-1:0] paddr,
	input  logic [ohlc_pkg::APB_DW-1:0] pwdata,
	output logic [ohlc_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import ohlc_pkg::*;

	localparam int IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int ENTRY_W = TS_W + 4 * PRICE_BITS;

	cfg_t cfg;

	ohlc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective bar length: zero acts as one nanosecond
	logic [LEN_W-1:0] len_eff;
	assign len_eff = (cfg.bar_length_ns == '0) ? LEN_W'(1) : cfg.bar_length_ns;

	// symbol screening at intake
	logic [SYM_W-1:0] sym_m1;
	logic             sym_ok;
	assign sym_m1 = tick.sym_code - 8'd1;
	assign sym_ok = (tick.sym_code != '0)
		&& (tick.sym_code <= {1'b0, cfg.active_symbols})
		&& (tick.sym_code <= SYM_W'(NUM_SYMBOLS));

	// price brought to table width, zero extended or truncated
	logic [PRICE_BITS+PX_W-1:0] px_ext;
	assign px_ext = {{PRICE_BITS{1'b0}}, tick.price};

	// sequencer state and per-tick holding registers
	ohlc_state_t         state_q, state_d;
	logic [IDX_W-1:0]    slot_q;
	logic [OUT_SYM_W-1:0] sym_q;
	logic [TS_W-1:0]     ts_q;
	logic [PRICE_BITS-1:0] px_q;

	logic accept;
	assign tick_stall = (state_q != ST_IDLE);
	assign accept     = tick_valid && !tick_stall;

	// table
	logic               rd_en;
	logic               rd_open;
	logic [ENTRY_W-1:0] rd_data;
	logic               tbl_wr;
	logic [ENTRY_W-1:0] wr_data;

	ohlc_table #(
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.ENTRY_W     (ENTRY_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (sym_m1[IDX_W-1:0]),
		.rd_open (rd_open),
		.rd_data (rd_data),
		.wr_en   (tbl_wr),
		.wr_addr (slot_q),
		.wr_data (wr_data)
	);

	// entry layout: start, open, high, low, close
	logic [TS_W-1:0]       e_start;
	logic [PRICE_BITS-1:0] e_open, e_high, e_low, e_close;
	assign {e_start, e_open, e_high, e_low, e_close} = rd_data;

	// rollover check: start plus length in 64 bits cannot wrap
	logic [TS_W:0] bar_end;
	logic          expired;
	logic          new_bar;
	assign bar_end = {1'b0, e_start} + {{(TS_W+1-LEN_W){1'b0}}, len_eff};
	assign expired = rd_open && ({1'b0, ts_q} >= bar_end);
	assign new_bar = !rd_open || expired;

	// remainder unit for flooring the tick time
	logic             rem_start;
	logic             rem_done;
	logic [LEN_W-1:0] rem;
	logic [TS_W-1:0]  floor_ts;

	ohlc_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (ts_q),
		.divisor   (len_eff),
		.done      (rem_done),
		.remainder (rem)
	);

	assign floor_ts = ts_q - {{(TS_W-LEN_W){1'b0}}, rem};

	// running high, low and close for an open bar
	logic [PRICE_BITS-1:0] upd_high, upd_low;
	assign upd_high = (px_q > e_high) ? px_q : e_high;
	assign upd_low  = (px_q < e_low) ? px_q : e_low;

	always_comb begin
		if (state_q == ST_REM) begin
			wr_data = {floor_ts, px_q, px_q, px_q, px_q};
		end else begin
			wr_data = {e_start, e_open, upd_high, upd_low, px_q};
		end
	end

	// output register
	logic bar_valid_q;
	bar_t bar_q;
	logic bar_load;
	logic out_free;
	assign out_free  = !bar_valid_q || !bar_stall;
	assign bar_valid = bar_valid_q;
	assign bar       = bar_q;

	// stored prices trimmed or extended to the output width
	function automatic logic [PX_W-1:0] to_out(input logic [PRICE_BITS-1:0] v);
		logic [PRICE_BITS+PX_W-1:0] w;
		w = {{PX_W{1'b0}}, v};
		return w[PX_W-1:0];
	endfunction

	// next state and control
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rem_start = 1'b0;
		bar_load  = 1'b0;
		tbl_wr    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sym_ok) begin
					rd_en   = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// a completed bar waits here until the output slot frees up
				if (!expired || out_free) begin
					bar_load = expired;
					if (new_bar) begin
						rem_start = 1'b1;
						state_d   = ST_REM;
					end else begin
						tbl_wr  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_REM: begin
				if (rem_done) begin
					tbl_wr  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bar_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (bar_load) begin
				bar_valid_q <= 1'b1;
			end else if (!bar_stall) begin
				bar_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= sym_m1[IDX_W-1:0];
			sym_q  <= tick.sym_code[OUT_SYM_W-1:0];
			ts_q   <= tick.timestamp_ns;
			px_q   <= px_ext[PRICE_BITS-1:0];
		end
		if (bar_load) begin
			bar_q.bar_symbol   <= sym_q;
			bar_q.bar_start_ns <= e_start;
			bar_q.bar_open     <= to_out(e_open);
			bar_q.bar_high     <= to_out(e_high);
			bar_q.bar_low      <= to_out(e_low);
			bar_q.bar_close    <= to_out(e_close);
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bar_load |-> out_free)
		else $error("completed bar loaded over a waiting transfer");

	a_rem_done_in_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == ST_REM)
		else $error("remainder result outside its wait state");

	a_write_timing: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr |=> state_q == ST_IDLE)
		else $error("table write not followed by idle");

	a_bar_symbol_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid_q |-> bar_q.bar_symbol != '0)
		else $error("completed bar with symbol zero");

endmodule

// ===== test/tick_to_ohlc_bar_aggregator_unit_tb.sv =====
// testbench for the ohlc bar aggregator: tick stimulus, bar prediction and checking
`timescale 1ns / 1ps

import ohlc_pkg::*;

// per-symbol bar table kept alongside the block, plus the queue of bars still owed
class bar_scoreboard;
	logic [LEN_W-1:0] bar_len;
	logic [ACT_W-1:0] active;
	bit               is_open  [NUM_SYMBOLS_DEF];
	logic [63:0]      start_ns [NUM_SYMBOLS_DEF];
	logic [PX_W-1:0]  open_px  [NUM_SYMBOLS_DEF];
	logic [PX_W-1:0]  high_px  [NUM_SYMBOLS_DEF];
	logic [PX_W-1:0]  low_px   [NUM_SYMBOLS_DEF];
	logic [PX_W-1:0]  close_px [NUM_SYMBOLS_DEF];
	bar_t             bars_due [$];
	int               errors;
	int               bars_seen;

	function new();
		bar_len   = BAR_LEN_RESET;
		active    = ACTIVE_RESET;
		errors    = 0;
		bars_seen = 0;
		foreach (is_open[i])
			is_open[i] = 1'b0;
	endfunction

	// zero length behaves as one nanosecond
	function logic [63:0] eff_len();
		return (bar_len == 0) ? 64'd1 : {17'b0, bar_len};
	endfunction

	function bit in_use(logic [SYM_W-1:0] sym);
		return sym != 0 && sym <= active && sym <= NUM_SYMBOLS_DEF;
	endfunction

	function void note_tick(tick_t t);
		logic [63:0] len;
		logic [63:0] ts;
		int          slot;
		bar_t        done;
		if (!in_use(t.sym_code))
			return;
		len  = eff_len();
		ts   = {1'b0, t.timestamp_ns};
		slot = t.sym_code - 1;
		// bar end formed in 64 bits, no wrap
		if (is_open[slot] && ts >= start_ns[slot] + len) begin
			done.bar_symbol   = t.sym_code[OUT_SYM_W-1:0];
			done.bar_start_ns = start_ns[slot][TS_W-1:0];
			done.bar_open     = open_px[slot];
			done.bar_high     = high_px[slot];
			done.bar_low      = low_px[slot];
			done.bar_close    = close_px[slot];
			bars_due.insert(bars_due.size(), done);
			is_open[slot] = 1'b0;
		end
		if (!is_open[slot]) begin
			is_open[slot]  = 1'b1;
			start_ns[slot] = (ts / len) * len;
			open_px[slot]  = t.price;
			high_px[slot]  = t.price;
			low_px[slot]   = t.price;
			close_px[slot] = t.price;
		end else begin
			if (t.price > high_px[slot])
				high_px[slot] = t.price;
			if (t.price < low_px[slot])
				low_px[slot] = t.price;
			close_px[slot] = t.price;
		end
	endfunction

	function void cmp(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	function void check_bar(bar_t got);
		bar_t want;
		if (bars_due.size() == 0) begin
			$display("%0t: bar expected none, got symbol %0d start %0d", $time,
				got.bar_symbol, got.bar_start_ns);
			errors++;
			return;
		end
		want = bars_due[0];
		bars_due.delete(0);
		bars_seen++;
		cmp("bar_symbol", 64'(want.bar_symbol), 64'(got.bar_symbol));
		cmp("bar_start_ns", 64'(want.bar_start_ns), 64'(got.bar_start_ns));
		cmp("bar_open", 64'(want.bar_open), 64'(got.bar_open));
		cmp("bar_high", 64'(want.bar_high), 64'(got.bar_high));
		cmp("bar_low", 64'(want.bar_low), 64'(got.bar_low));
		cmp("bar_close", 64'(want.bar_close), 64'(got.bar_close));
	endfunction
endclass

module tick_to_ohlc_bar_aggregator_unit_tb;

	localparam int  CYCLE_LIMIT = 1_000_000;
	localparam int  HOLD_CYCLES = 1500;
	localparam int  SETTLE      = 100;
	localparam logic [62:0] TS_MAX = {63{1'b1}};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              tick_valid = 1'b0;
	logic              tick_stall;
	tick_t             tick      = '0;
	logic              bar_valid;
	logic              bar_stall = 1'b0;
	bar_t              bar;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bar_scoreboard sb;
	int            cycles    = 0;
	int            hold_left = 0;
	bit            held      = 1'b0;
	logic [63:0]   clock_ns  = 64'd0;
	logic [31:0]   px_walk   = 32'd50000;

	tick_to_ohlc_bar_aggregator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.bar_valid  (bar_valid),
		.bar_stall  (bar_stall),
		.bar        (bar),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tick_to_ohlc_bar_aggregator_unit_tb: done, errors");
			$finish;
		end
	end

	// no idling on either side in the first quarter of each repeating window of cycles
	function automatic bit calm();
		return (cycles % 20000) < 5000;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// bar side stall: random idling, plus one long hold-off once bars are flowing
	always @(negedge clk) begin
		if (!held && sb != null && sb.bars_seen >= 40) begin
			held      = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			bar_stall <= 1'b1;
			hold_left--;
		end else
			bar_stall <= !calm() && ($urandom_range(0, 99) < 20);
	end

	// a bar transfer happens at an edge with valid high and stall low
	always @(posedge clk) begin
		if (arst_n && bar_valid && !bar_stall)
			sb.check_bar(bar);
	end

	// one tick transfer; valid stays high into the next call unless an idle cycle is drawn
	task automatic send_tick(input logic [7:0] sym, input logic [62:0] ts, input logic [31:0] px);
		tick_t t;
		t.sym_code     = sym;
		t.timestamp_ns = ts;
		t.price        = px;
		@(negedge clk);
		while (!calm() && $urandom_range(0, 99) < 20) begin
			tick_valid <= 1'b0;
			@(negedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= t;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		sb.note_tick(t);
	endtask

	// drop valid, wait for every owed bar, then let any bar-opening tick finish
	task automatic drain();
		@(negedge clk);
		tick_valid <= 1'b0;
		while (sb.bars_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write, then read back in a second transfer with psel held
	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [63:0] val);
		logic [63:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (addr)
			ADDR_BAR_LEN: sb.bar_len = val[LEN_W-1:0];
			ADDR_ACTIVE:  sb.active  = val[ACT_W-1:0];
			default: ;
		endcase
		want = (addr == ADDR_BAR_LEN) ? {17'b0, sb.bar_len} : {57'b0, sb.active};
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d expected %0d got %0d", $time, addr, want, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly well-formed ticks on a rising time base, a few per bar per symbol,
	// with bar edges, ticks before bar start and some noise symbols and times
	task automatic run_phase(input int goal);
		logic [63:0] len;
		logic [63:0] span;
		logic [63:0] edge_ns;
		logic [63:0] jitter;
		logic [63:0] ts;
		logic [7:0]  sym;
		logic [31:0] px;
		int          nsym;
		int          used;
		int          raw;
		int          pick;
		len  = sb.eff_len();
		nsym = (sb.active > NUM_SYMBOLS_DEF) ? NUM_SYMBOLS_DEF : sb.active;
		if (nsym == 0)
			nsym = 1;
		used = 0;
		raw  = 0;
		while (used < goal && raw < 4 * goal) begin
			span = (len * 2) / (nsym * $urandom_range(1, 4) * 3);
			if (span < 2)
				span = 2;
			clock_ns = clock_ns + rand64() % (span + 1);
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				sym     = 8'($urandom_range(1, nsym));
				edge_ns = (clock_ns / len) * len;
				pick    = $urandom_range(0, 99);
				if (pick < 70)
					ts = clock_ns;
				else if (pick < 80)
					ts = edge_ns;
				else if (pick < 90)
					ts = (edge_ns == 0) ? 64'd0 : edge_ns - 1;
				else begin
					// up to one bar length before the running time, possibly before the open bar's start
					jitter = rand64() % (len + 1);
					ts     = (clock_ns > jitter) ? clock_ns - jitter : 64'd0;
				end
			end else begin
				sym  = 8'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (pick < 5)
					ts = rand64() >> 1;
				else if (pick < 8)
					ts = {1'b0, TS_MAX};
				else
					ts = clock_ns;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				px_walk = px_walk + $urandom_range(0, 2000) - 32'd1000;
				px      = px_walk;
			end else if (pick < 90)
				px = $urandom;
			else if (pick < 95)
				px = 32'd0;
			else
				px = 32'hffff_ffff;
			send_tick(sym, ts[62:0], px);
			raw++;
			if (sb.in_use(sym))
				used++;
		end
	endtask

	initial begin
		logic [63:0] phase_len   [7];
		logic [63:0] phase_act   [7];
		int          phase_items [7];
		sb = new();
		// short, long, random, zero length, no symbols, widest field, default length
		phase_len[0] = 64'd1_000_000_000;      phase_act[0] = 64; phase_items[0] = 350;
		phase_len[1] = 64'd86_400_000_000_000; phase_act[1] = 1;  phase_items[1] = 250;
		phase_len[2] = 64'd1_000_000_000 + rand64() % 64'd86_399_000_000_001;
		phase_act[2] = 64'($urandom_range(1, 64)); phase_items[2] = 300;
		phase_len[3] = 64'd0;                  phase_act[3] = 8;  phase_items[3] = 250;
		phase_len[4] = 64'd1_000_000_000;      phase_act[4] = 0;  phase_items[4] = 10;
		phase_len[5] = 64'h7fff_ffff_ffff;     phase_act[5] = 127; phase_items[5] = 300;
		phase_len[6] = 64'd60_000_000_000;     phase_act[6] = 3;  phase_items[6] = 300;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, at reset settings: ignored symbols, extremes, bar edges
		send_tick(8'd0, 63'd0, 32'hffff_ffff);
		send_tick(8'd65, 63'd100, 32'd5);
		send_tick(8'd255, TS_MAX, 32'hffff_ffff);
		send_tick(8'd1, 63'd0, 32'd100);
		send_tick(8'd1, 63'd10, 32'hffff_ffff);
		send_tick(8'd1, 63'd20, 32'd0);
		send_tick(8'd1, 63'd59_999_999_999, 32'd500);
		send_tick(8'd1, 63'd60_000_000_000, 32'd42);
		send_tick(8'd64, TS_MAX, 32'd7);
		send_tick(8'd64, 63'd0, 32'd8);
		send_tick(8'd64, TS_MAX, 32'd3);
		send_tick(8'd1, 63'd5, 32'd1);
		send_tick(8'd2, 63'd123_456_789_012, 32'h8000_0000);
		send_tick(8'd2, 63'd423_456_789_012, 32'h7fff_ffff);
		send_tick(8'd2, 63'd423_456_789_013, 32'd77);
		send_tick(8'd63, 63'd0, 32'd9);
		send_tick(8'd63, TS_MAX, 32'd10);

		for (int p = 0; p < 7; p++) begin
			drain();
			write_reg(ADDR_BAR_LEN, phase_len[p]);
			write_reg(ADDR_ACTIVE, phase_act[p]);
			run_phase(phase_items[p]);
		end
		drain();

		if (sb.errors == 0)
			$display("tick_to_ohlc_bar_aggregator_unit_tb: done, clean");
		else
			$display("tick_to_ohlc_bar_aggregator_unit_tb: done, errors");
		$finish;
	end

endmodule
